// File: rtl/mbe_pkg.sv
`default_nettype none
package mbe_pkg;

  localparam int FRAC_BITS        = 56;
  localparam int SMOOTH_FRAC_BITS = 16;
  localparam int LFRAC            = 32;
  localparam int MAG_LIMIT_BITS   = 31;

  localparam logic [15:0] DEFAULT_MAX_ITER = 16'd2000;
  localparam logic [16:0] FIRST_CHECK      = 17'd20;
  localparam logic [63:0] FIVE_POW20       = 64'd95367431640625;

  localparam logic signed [63:0] FX_ONE       = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] FX_QUARTER   = 64'sd1 <<< (FRAC_BITS - 2);
  localparam logic signed [63:0] FX_SIXTEENTH = 64'sd1 <<< (FRAC_BITS - 4);
  localparam logic signed [63:0] FX_FOUR      = 64'sd1 <<< (FRAC_BITS + 2);
  localparam logic signed [63:0] S64_MAX      = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN      = {1'b1, {63{1'b0}}};

  localparam logic [2:0] OUT_ESCAPED  = 3'd0;
  localparam logic [2:0] OUT_CARDIOID = 3'd1;
  localparam logic [2:0] OUT_BULB     = 3'd2;
  localparam logic [2:0] OUT_PERIODIC = 3'd3;
  localparam logic [2:0] OUT_LIMIT    = 3'd4;

  typedef struct packed {
    logic               start;
    logic               sgn;
    logic               half;
    logic [63:0]        a;
    logic [63:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
    logic [127:0]       prod;
  } mul_rsp_t;

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] d);
    return d[63] ? (~d + 64'd1) : d;
  endfunction

  function automatic logic [63:0] close_threshold(input int frac);
    logic [63:0] rem;
    logic [63:0] q;
    rem = 64'd1;
    q   = 64'd0;
    for (int i = 0; i < 2 * frac - 20; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= FIVE_POW20) begin
        rem = rem - FIVE_POW20;
        q   = q | 64'd1;
      end
    end
    return (rem != 64'd0) ? q + 64'd1 : q;
  endfunction

  localparam logic [63:0] CLOSE_THR = close_threshold(FRAC_BITS);

endpackage
`default_nettype wire

// File: rtl/mbe_mul.sv
`default_nettype none
module mbe_mul (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mbe_pkg::mul_req_t req,
  output mbe_pkg::mul_rsp_t     rsp
);

  localparam int F = mbe_pkg::FRAC_BITS;
  localparam logic [127:0] MASK_F = (128'd1 << F) - 128'd1;
  localparam logic [127:0] MASK_H = (128'd1 << (F - 1)) - 128'd1;

  typedef enum logic [1:0] {M_IDLE, M_PROD, M_ACC, M_POST} mstate_t;

  mstate_t            state_r;
  logic [63:0]        ua_r;
  logic [63:0]        ub_r;
  logic               neg_r;
  logic               half_r;
  logic [1:0]         idx_r;
  logic [63:0]        p_r;
  logic [127:0]       acc_r;
  logic               done_r;
  logic signed [63:0] res_r;

  logic [31:0]        opa;
  logic [31:0]        opb;
  logic [63:0]        p_nxt;
  logic [127:0]       addend;
  logic [127:0]       q;
  logic               rem;
  logic               hi_nz;
  logic [64:0]        qn;
  logic signed [63:0] post;

  always_comb begin
    opa   = idx_r[1] ? ua_r[63:32] : ua_r[31:0];
    opb   = idx_r[0] ? ub_r[63:32] : ub_r[31:0];
    p_nxt = {32'b0, opa} * {32'b0, opb};
    unique case (idx_r)
      2'd0:    addend = {64'b0, p_r};
      2'd3:    addend = {p_r, 64'b0};
      default: addend = {32'b0, p_r, 32'b0};
    endcase
  end

  always_comb begin
    q     = half_r ? (acc_r >> (F - 1)) : (acc_r >> F);
    rem   = half_r ? |(acc_r & MASK_H) : |(acc_r & MASK_F);
    hi_nz = |q[127:64];
    qn    = {1'b0, q[63:0]} + {64'b0, rem};
    if (neg_r) begin
      post = (hi_nz || qn[64] || qn[63]) ? mbe_pkg::S64_MIN : (~qn[63:0] + 64'd1);
    end else begin
      post = (hi_nz || q[63]) ? mbe_pkg::S64_MAX : q[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (req.start) begin
            ua_r    <= (req.sgn && req.a[63]) ? (~req.a + 64'd1) : req.a;
            ub_r    <= (req.sgn && req.b[63]) ? (~req.b + 64'd1) : req.b;
            neg_r   <= req.sgn && (req.a[63] ^ req.b[63]);
            half_r  <= req.half;
            acc_r   <= '0;
            idx_r   <= 2'd0;
            state_r <= M_PROD;
          end
        end
        M_PROD: begin
          p_r     <= p_nxt;
          state_r <= M_ACC;
        end
        M_ACC: begin
          acc_r <= acc_r + addend;
          if (idx_r == 2'd3) begin
            state_r <= M_POST;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= M_PROD;
          end
        end
        M_POST: begin
          res_r   <= post;
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;
  assign rsp.prod = acc_r;

endmodule
`default_nettype wire

// File: rtl/mandelbrot_escape_time.sv
// channel | ports                                    | handshake
// in      | in_c_real, in_c_imag                     | start while busy low
// out     | out_outcome, out_iterations,             | out_valid, one cycle
//         | out_smooth_count                         |
// cfg     | cfg_wdata                                | cfg_we
// each 64-bit product runs on the shared 32x32 multiplier
// (four partial products, then round and saturate)
// reset is synchronous; max_iterations returns to 2000
// the receiver cannot stall: each word is shown for one cycle only
`default_nettype none
module mandelbrot_escape_time (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [63:0] in_c_real,
  input  wire logic signed [63:0] in_c_imag,
  output logic                    out_valid,
  output logic [2:0]              out_outcome,
  output logic [15:0]             out_iterations,
  output logic signed [31:0]      out_smooth_count,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata
);

  localparam int F = mbe_pkg::FRAC_BITS;
  localparam int S = mbe_pkg::SMOOTH_FRAC_BITS;
  localparam int L = mbe_pkg::LFRAC;
  localparam logic [63:0] L_ONE = 64'd1 << L;
  localparam logic signed [65:0] V_MAX = 66'sd2147483647;
  localparam logic signed [65:0] V_MIN = -66'sd2147483648;

  typedef enum logic [4:0] {
    S_IDLE, S_CI2, S_XS2, S_QQ, S_QC, S_XP2, S_TEST, S_ZI, S_ZR2, S_ZI2,
    S_CHECK, S_MR, S_MI, S_DECIDE, S_LNORM, S_LSQ, S_LEND
  } state_t;

  state_t             state_r;
  logic               wait_r;
  logic [15:0]        max_iter_r;
  logic signed [63:0] cr_r, ci_r, xs_r, xp_r, ci2_r, q_r, a_r;
  logic signed [63:0] zr_r, zi_r, zr2_r, zi2_r, oldr_r, oldi_r;
  logic [15:0]        n_r;
  logic [16:0]        chk_r;
  logic [63:0]        sq_r;
  logic [63:0]        mr_r, mi_r;
  logic [63:0]        lg_x_r;
  logic [5:0]         lg_msb_r;
  logic [31:0]        lg_frac_r;
  logic [4:0]         lg_cnt_r;
  logic               lg_pass_r;
  logic [63:0]        lg_res_r;
  logic               out_valid_r;
  logic [2:0]         out_outcome_r;
  logic [15:0]        out_iterations_r;
  logic signed [31:0] out_smooth_r;

  mbe_pkg::mul_req_t  req;
  mbe_pkg::mul_rsp_t  rsp;

  logic signed [63:0] mag2;
  logic signed [63:0] dr, di;
  logic [63:0]        mr, mi;
  logic [63:0]        hi, lo;
  logic [31:0]        frac_nxt;
  logic [5:0]         xfrac;
  logic [63:0]        nu;
  logic signed [65:0] v;
  logic signed [31:0] smooth;
  logic               mul_state;

  mbe_mul u_mul (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  always_comb begin
    mul_state = (state_r inside {S_CI2, S_XS2, S_QQ, S_QC, S_XP2, S_ZI, S_ZR2,
                                 S_ZI2, S_MR, S_MI, S_LSQ});
    req       = '0;
    req.start = mul_state && !wait_r;
    req.sgn   = 1'b1;
    case (state_r)
      S_CI2:   begin req.a = ci_r;  req.b = ci_r; end
      S_XS2:   begin req.a = xs_r;  req.b = xs_r; end
      S_QQ:    begin req.a = q_r;   req.b = mbe_pkg::sadd(q_r, xs_r); end
      S_QC:    begin req.a = mbe_pkg::FX_QUARTER; req.b = ci2_r; end
      S_XP2:   begin req.a = xp_r;  req.b = xp_r; end
      S_ZI:    begin req.a = zr_r;  req.b = zi_r; req.half = 1'b1; end
      S_ZR2:   begin req.a = zr_r;  req.b = zr_r; end
      S_ZI2:   begin req.a = zi_r;  req.b = zi_r; end
      S_MR:    begin req.a = mr_r;  req.b = mr_r; req.sgn = 1'b0; end
      S_MI:    begin req.a = mi_r;  req.b = mi_r; req.sgn = 1'b0; end
      S_LSQ:   begin req.a = lg_x_r; req.b = lg_x_r; req.sgn = 1'b0; end
      default: begin req.a = '0;    req.b = '0; end
    endcase
  end

  always_comb begin
    mag2     = mbe_pkg::sadd(zr2_r, zi2_r);
    dr       = mbe_pkg::ssub(zr_r, oldr_r);
    di       = mbe_pkg::ssub(zi_r, oldi_r);
    mr       = mbe_pkg::mag(dr);
    mi       = mbe_pkg::mag(di);
    hi       = rsp.prod[127:64];
    lo       = rsp.prod[63:0];
    frac_nxt = {lg_frac_r[30:0], hi[63]};
    xfrac    = lg_pass_r ? 6'(L) : 6'(F);
    nu       = (lg_res_r >= L_ONE) ? (lg_res_r - L_ONE) : 64'd0;
    v        = $signed(66'({1'b0, n_r} + 17'd1) << S) - $signed(66'(nu >> (L - S)));
    if (v > V_MAX) begin
      smooth = V_MAX[31:0];
    end else if (v < V_MIN) begin
      smooth = V_MIN[31:0];
    end else begin
      smooth = v[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      max_iter_r  <= mbe_pkg::DEFAULT_MAX_ITER;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        max_iter_r <= cfg_wdata;
      end
      if (req.start) begin
        wait_r <= 1'b1;
      end else if (rsp.done) begin
        wait_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cr_r    <= in_c_real;
            ci_r    <= in_c_imag;
            xs_r    <= mbe_pkg::ssub(in_c_real, mbe_pkg::FX_QUARTER);
            xp_r    <= mbe_pkg::sadd(in_c_real, mbe_pkg::FX_ONE);
            state_r <= S_CI2;
          end
        end
        S_CI2: begin
          if (rsp.done) begin
            ci2_r   <= rsp.res;
            state_r <= S_XS2;
          end
        end
        S_XS2: begin
          if (rsp.done) begin
            q_r     <= mbe_pkg::sadd(rsp.res, ci2_r);
            state_r <= S_QQ;
          end
        end
        S_QQ: begin
          if (rsp.done) begin
            a_r     <= rsp.res;
            state_r <= S_QC;
          end
        end
        S_QC: begin
          if (rsp.done) begin
            if (a_r < rsp.res) begin
              out_valid_r      <= 1'b1;
              out_outcome_r    <= mbe_pkg::OUT_CARDIOID;
              out_iterations_r <= '0;
              out_smooth_r     <= '0;
              state_r          <= S_IDLE;
            end else begin
              state_r <= S_XP2;
            end
          end
        end
        S_XP2: begin
          if (rsp.done) begin
            if (mbe_pkg::sadd(rsp.res, ci2_r) < mbe_pkg::FX_SIXTEENTH) begin
              out_valid_r      <= 1'b1;
              out_outcome_r    <= mbe_pkg::OUT_BULB;
              out_iterations_r <= '0;
              out_smooth_r     <= '0;
              state_r          <= S_IDLE;
            end else begin
              zr_r    <= '0;
              zi_r    <= '0;
              zr2_r   <= '0;
              zi2_r   <= '0;
              oldr_r  <= '0;
              oldi_r  <= '0;
              n_r     <= '0;
              chk_r   <= mbe_pkg::FIRST_CHECK;
              state_r <= S_TEST;
            end
          end
        end
        S_TEST: begin
          if (mag2 > mbe_pkg::FX_FOUR || n_r >= max_iter_r) begin
            state_r <= S_DECIDE;
          end else begin
            state_r <= S_ZI;
          end
        end
        S_ZI: begin
          if (rsp.done) begin
            zi_r    <= mbe_pkg::sadd(rsp.res, ci_r);
            zr_r    <= mbe_pkg::sadd(mbe_pkg::ssub(zr2_r, zi2_r), cr_r);
            state_r <= S_ZR2;
          end
        end
        S_ZR2: begin
          if (rsp.done) begin
            zr2_r   <= rsp.res;
            state_r <= S_ZI2;
          end
        end
        S_ZI2: begin
          if (rsp.done) begin
            zi2_r   <= rsp.res;
            n_r     <= n_r + 16'd1;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if ({1'b0, n_r} == chk_r) begin
            if (mr[63:mbe_pkg::MAG_LIMIT_BITS] != '0 ||
                mi[63:mbe_pkg::MAG_LIMIT_BITS] != '0) begin
              oldr_r  <= zr_r;
              oldi_r  <= zi_r;
              chk_r   <= chk_r << 1;
              state_r <= S_TEST;
            end else begin
              mr_r    <= mr;
              mi_r    <= mi;
              state_r <= S_MR;
            end
          end else begin
            state_r <= S_TEST;
          end
        end
        S_MR: begin
          if (rsp.done) begin
            sq_r    <= lo;
            state_r <= S_MI;
          end
        end
        S_MI: begin
          if (rsp.done) begin
            if (sq_r + lo < mbe_pkg::CLOSE_THR) begin
              out_valid_r      <= 1'b1;
              out_outcome_r    <= mbe_pkg::OUT_PERIODIC;
              out_iterations_r <= n_r;
              out_smooth_r     <= '0;
              state_r          <= S_IDLE;
            end else begin
              oldr_r  <= zr_r;
              oldi_r  <= zi_r;
              chk_r   <= chk_r << 1;
              state_r <= S_TEST;
            end
          end
        end
        S_DECIDE: begin
          if (n_r == max_iter_r) begin
            out_valid_r      <= 1'b1;
            out_outcome_r    <= mbe_pkg::OUT_LIMIT;
            out_iterations_r <= n_r;
            out_smooth_r     <= '0;
            state_r          <= S_IDLE;
          end else begin
            lg_x_r    <= mag2;
            lg_msb_r  <= 6'd63;
            lg_pass_r <= 1'b0;
            state_r   <= S_LNORM;
          end
        end
        S_LNORM: begin
          if (lg_x_r == '0) begin
            lg_res_r <= '0;
            state_r  <= S_LEND;
          end else if (lg_x_r[63]) begin
            if (lg_msb_r < xfrac) begin
              lg_res_r <= '0;
              state_r  <= S_LEND;
            end else begin
              lg_frac_r <= '0;
              lg_cnt_r  <= '0;
              state_r   <= S_LSQ;
            end
          end else begin
            lg_x_r   <= lg_x_r << 1;
            lg_msb_r <= lg_msb_r - 6'd1;
          end
        end
        S_LSQ: begin
          if (rsp.done) begin
            lg_frac_r <= frac_nxt;
            lg_x_r    <= hi[63] ? hi : {hi[62:0], lo[63]};
            lg_cnt_r  <= lg_cnt_r + 5'd1;
            if (lg_cnt_r == 5'd31) begin
              lg_res_r <= {26'b0, lg_msb_r - xfrac, frac_nxt};
              state_r  <= S_LEND;
            end
          end
        end
        S_LEND: begin
          if (!lg_pass_r) begin
            lg_x_r    <= lg_res_r;
            lg_msb_r  <= 6'd63;
            lg_pass_r <= 1'b1;
            state_r   <= S_LNORM;
          end else begin
            out_valid_r      <= 1'b1;
            out_outcome_r    <= mbe_pkg::OUT_ESCAPED;
            out_iterations_r <= n_r;
            out_smooth_r     <= smooth;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_outcome      = out_outcome_r;
  assign out_iterations   = out_iterations_r;
  assign out_smooth_count = out_smooth_r;

endmodule
`default_nettype wire

// File: bench/mbe_checker.sv
`timescale 1ns / 1ps
module mbe_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic signed [63:0] in_c_real,
  input  wire logic signed [63:0] in_c_imag,
  input  wire logic               out_valid,
  input  wire logic [2:0]         out_outcome,
  input  wire logic [15:0]        out_iterations,
  input  wire logic signed [31:0] out_smooth_count,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  output int                      errors,
  output int                      pending
);

  typedef logic signed [63:0] fx_t;

  typedef struct {
    logic [2:0]         outcome;
    logic [15:0]        iters;
    logic signed [31:0] smooth;
  } escape_word_t;

  escape_word_t expected_words[$];
  logic [15:0]  iter_limit;
  logic [63:0]  near_thr;

  initial begin
    logic [127:0] p5;
    p5 = 128'd95367431640625;
    near_thr = 64'(((128'd1 << (2 * mbe_pkg::FRAC_BITS - 20)) + p5 - 128'd1) / p5);
    errors = 0;
  end

  assign pending = expected_words.size();

  function automatic fx_t clamp64(input logic signed [127:0] v);
    if (v > $signed(mbe_pkg::S64_MAX)) return mbe_pkg::S64_MAX;
    if (v < $signed(mbe_pkg::S64_MIN)) return mbe_pkg::S64_MIN;
    return v[63:0];
  endfunction

  function automatic fx_t fx_mul(input fx_t a, input fx_t b, input int sh);
    logic signed [127:0] pa;
    logic signed [127:0] pb;
    pa = a;
    pb = b;
    pa = (pa * pb) >>> sh;
    return clamp64(pa);
  endfunction

  function automatic fx_t fx_add(input fx_t a, input fx_t b);
    logic signed [127:0] s;
    s = a;
    s = s + b;
    return clamp64(s);
  endfunction

  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    logic signed [127:0] s;
    s = a;
    s = s - b;
    return clamp64(s);
  endfunction

  function automatic logic [63:0] abs64(input fx_t d);
    return d[63] ? 64'(-d) : 64'(d);
  endfunction

  function automatic bit orbit_closed(input fx_t dr, input fx_t di);
    logic [63:0] mr;
    logic [63:0] mi;
    mr = abs64(dr);
    mi = abs64(di);
    if (mr >= 64'd1 << 31 || mi >= 64'd1 << 31) return 0;
    return (mr * mr + mi * mi) < near_thr;
  endfunction

  function automatic logic [63:0] log2_q32(input logic [63:0] x, input int xfrac);
    int          msb;
    logic [63:0] mant;
    logic [63:0] frac;
    logic [127:0] sq;
    if (x == 0) return 0;
    msb = 63;
    while (!x[msb]) msb--;
    if (msb < xfrac) return 0;
    mant = x << (63 - msb);
    frac = 0;
    for (int i = 0; i < mbe_pkg::LFRAC; i++) begin
      sq = mant * mant;
      frac = frac << 1;
      if (sq[127]) begin
        frac[0] = 1'b1;
        mant = sq[127:64];
      end else begin
        mant = sq[126:63];
      end
    end
    return (64'(msb - xfrac) << mbe_pkg::LFRAC) | frac;
  endfunction

  function automatic escape_word_t escape_time(input fx_t cr, input fx_t ci,
                                               input logic [15:0] lim);
    escape_word_t r;
    fx_t ci2, xs, q, xp, zr, zi, zr2, zi2, oldr, oldi;
    int unsigned n, next_chk, period;
    bit periodic;
    logic [63:0] l2m, l2l, nu;
    longint v;
    r.outcome = mbe_pkg::OUT_ESCAPED;
    r.iters = 0;
    r.smooth = 0;
    ci2 = fx_mul(ci, ci, mbe_pkg::FRAC_BITS);
    xs = fx_sub(cr, mbe_pkg::FX_QUARTER);
    q = fx_add(fx_mul(xs, xs, mbe_pkg::FRAC_BITS), ci2);
    xp = fx_add(cr, mbe_pkg::FX_ONE);
    if (fx_mul(q, fx_add(q, xs), mbe_pkg::FRAC_BITS) <
        fx_mul(mbe_pkg::FX_QUARTER, ci2, mbe_pkg::FRAC_BITS)) begin
      r.outcome = mbe_pkg::OUT_CARDIOID;
      return r;
    end
    if (fx_add(fx_mul(xp, xp, mbe_pkg::FRAC_BITS), ci2) < mbe_pkg::FX_SIXTEENTH) begin
      r.outcome = mbe_pkg::OUT_BULB;
      return r;
    end
    zr = 0; zi = 0; zr2 = 0; zi2 = 0; oldr = 0; oldi = 0;
    n = 0; next_chk = 20; period = 20; periodic = 0;
    while (fx_add(zr2, zi2) <= mbe_pkg::FX_FOUR && n < lim) begin
      zi = fx_add(fx_mul(zr, zi, mbe_pkg::FRAC_BITS - 1), ci);
      zr = fx_add(fx_sub(zr2, zi2), cr);
      zr2 = fx_mul(zr, zr, mbe_pkg::FRAC_BITS);
      zi2 = fx_mul(zi, zi, mbe_pkg::FRAC_BITS);
      n++;
      if (n == next_chk) begin
        if (orbit_closed(fx_sub(zr, oldr), fx_sub(zi, oldi))) begin
          periodic = 1;
          break;
        end
        oldr = zr;
        oldi = zi;
        next_chk += period;
        period *= 2;
      end
    end
    r.iters = n[15:0];
    if (periodic) begin
      r.outcome = mbe_pkg::OUT_PERIODIC;
    end else if (n == lim) begin
      r.outcome = mbe_pkg::OUT_LIMIT;
    end else begin
      l2m = log2_q32(64'(fx_add(zr2, zi2)), mbe_pkg::FRAC_BITS);
      l2l = log2_q32(l2m, mbe_pkg::LFRAC);
      nu = (l2l >= 64'd1 << mbe_pkg::LFRAC) ? l2l - (64'd1 << mbe_pkg::LFRAC) : 64'd0;
      v = longint'(n + 1) * (longint'(1) << mbe_pkg::SMOOTH_FRAC_BITS)
          - longint'(nu >> (mbe_pkg::LFRAC - mbe_pkg::SMOOTH_FRAC_BITS));
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      r.smooth = v[31:0];
      r.outcome = mbe_pkg::OUT_ESCAPED;
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    escape_word_t w;
    if (!rst_n) begin
      iter_limit <= mbe_pkg::DEFAULT_MAX_ITER;
      expected_words.delete();
    end else begin
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          report("unexpected word", {61'd0, out_outcome}, 64'd0);
        end else begin
          w = expected_words.pop_front();
          if (out_outcome !== w.outcome)
            report("outcome", 64'(out_outcome), 64'(w.outcome));
          if (out_iterations !== w.iters)
            report("iterations", 64'(out_iterations), 64'(w.iters));
          if (out_smooth_count !== w.smooth)
            report("smooth_count", 64'(out_smooth_count), 64'(w.smooth));
        end
      end
      if (start && !busy)
        expected_words.push_back(escape_time(in_c_real, in_c_imag, iter_limit));
      if (cfg_we) iter_limit <= cfg_wdata;
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic signed [63:0] in_c_real = 0;
  logic signed [63:0] in_c_imag = 0;
  logic               out_valid;
  logic [2:0]         out_outcome;
  logic [15:0]        out_iterations;
  logic signed [31:0] out_smooth_count;
  logic               cfg_we = 0;
  logic [15:0]        cfg_wdata = 0;
  int                 errors;
  int                 pending;
  int                 idle_cycles = 0;

  localparam int WATCHDOG_LIMIT = 400000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  mandelbrot_escape_time dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_c_real(in_c_real), .in_c_imag(in_c_imag),
    .out_valid(out_valid), .out_outcome(out_outcome),
    .out_iterations(out_iterations), .out_smooth_count(out_smooth_count),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  mbe_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_c_real(in_c_real), .in_c_imag(in_c_imag),
    .out_valid(out_valid), .out_outcome(out_outcome),
    .out_iterations(out_iterations), .out_smooth_count(out_smooth_count),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic signed [63:0] fx(input real r);
    return longint'(r * (2.0 ** mbe_pkg::FRAC_BITS));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // start stays high across back-to-back words
  task automatic send(input logic signed [63:0] cr, input logic signed [63:0] ci,
                      input int gap);
    start <= 1;
    in_c_real <= cr;
    in_c_imag <= ci;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (start) begin
      start <= 0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [15:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_random(input int gap);
    logic signed [63:0] cr;
    logic signed [63:0] ci;
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      cr = fx(-2.5) + $signed({6'd0, 26'($urandom_range(0, 32'h3ff_ffff)), $urandom()});
      ci = fx(-1.5) + $signed({6'd0, 26'($urandom_range(0, 32'h2ff_ffff)), $urandom()});
    end else if (r < 90) begin
      cr = fx(-0.75) + $signed({{40{1'b0}}, 24'($urandom())}) - 64'sd8388608;
      ci = $signed({{30{1'b0}}, 34'({$urandom(), $urandom()})}) - (64'sd1 <<< 33);
    end else begin
      cr = {$urandom(), $urandom()};
      ci = {$urandom(), $urandom()};
    end
    send(cr, ci, gap);
  endtask

  initial begin
    logic [15:0] lim;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(fx(0.0), fx(0.0), 0);
    send(fx(-1.0), fx(0.0), 0);
    send(fx(2.0), fx(0.0), 1);
    send(mbe_pkg::S64_MAX, mbe_pkg::S64_MAX, 0);
    send(mbe_pkg::S64_MIN, mbe_pkg::S64_MIN, 3);
    send(mbe_pkg::S64_MAX, mbe_pkg::S64_MIN, 0);
    send(mbe_pkg::S64_MIN, mbe_pkg::S64_MAX, 0);
    send(fx(0.25), fx(0.0), 2);
    send(fx(-2.0), fx(0.0), 0);
    send(fx(-0.12), fx(0.75), 0);
    send(fx(-1.75), fx(0.0), 5);
    send(fx(0.0), fx(1.0), 0);
    send(fx(0.3), fx(0.5), 0);
    send(fx(-0.75), fx(0.1), 30);
    drain();

    set_limit(16'd1);
    send(fx(0.0), fx(1.0), 0);
    send(fx(2.0), fx(0.0), 0);
    send(fx(0.3), fx(0.5), 0);
    drain();

    set_limit(16'hffff);
    send(fx(0.0), fx(0.0), 0);
    send(fx(-1.0), fx(0.0), 0);
    send(fx(2.0), fx(0.0), 0);
    send(fx(1.0), fx(1.0), 0);
    send(mbe_pkg::S64_MAX, fx(0.0), 0);
    drain();

    set_limit(16'd0);
    send(fx(0.3), fx(0.5), 0);
    send(fx(-2.0), fx(0.0), 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      lim = (ph == 0) ? 16'd1 : 16'($urandom_range(2, 100));
      set_limit(lim);
      for (int i = 0; i < 70; i++) send_random((ph == 2) ? 0 : pick_gap());
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/mbe_pkg.sv
rtl/mbe_mul.sv
rtl/mandelbrot_escape_time.sv
bench/mbe_checker.sv
bench/tb.sv
